// ===== rtl/trme_pkg.sv =====
// shared types and constants for the toy register machine execute block
// no dependencies

package trme_pkg;

  // machine sizes
  localparam int DATA_W     = 32;
  localparam int NUM_REGS   = 5;
  localparam int PROG_DEPTH = 256;
  localparam int IP_W       = $clog2(PROG_DEPTH);
  localparam int IDX_W      = 3;
  localparam int IMM_W      = 8;
  localparam int OP_W       = 4;

  // register index of the instruction pointer
  localparam logic [IDX_W-1:0] IP_INDEX = IDX_W'(NUM_REGS);

  // item modes
  localparam logic MODE_EXEC   = 1'b0;
  localparam logic MODE_PRESET = 1'b1;

  // opcodes; every other code is a no-op
  typedef enum logic [OP_W-1:0] {
    OP_HALT    = 4'd0,
    OP_LOADIMM = 4'd1,
    OP_ADD     = 4'd2,
    OP_ADDIMM  = 4'd3,
    OP_AND     = 4'd4,
    OP_OR      = 4'd5,
    OP_XOR     = 4'd6,
    OP_JUMP    = 4'd7,
    OP_BEQ     = 4'd8,
    OP_MOVE    = 4'd9
  } op_t;

  // one input item
  typedef struct packed {
    logic                     mode;
    logic [OP_W-1:0]          opcode;
    logic [IDX_W-1:0]         source_index;
    logic [IDX_W-1:0]         dest_index;
    logic signed [IMM_W-1:0]  immediate;
    logic signed [DATA_W-1:0] preset_value;
  } instr_t;

  // one result item
  typedef struct packed {
    logic [IP_W-1:0]                        next_ip;
    logic                                   halted;
    logic [NUM_REGS-1:0][DATA_W-1:0]        regs;
  } result_t;

endpackage

// ===== rtl/trme_in_reg.sv =====
// input register of the execute block: holds one accepted item
// depends on trme_pkg

module trme_in_reg
  import trme_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_stall,
  input  instr_t in_item,
  input  logic   advance,
  output logic   held_valid,
  output instr_t held_item
);

  logic load;

  // stall only while a held item cannot move on
  assign in_stall = held_valid & ~advance;
  assign load     = in_valid & ~in_stall;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (load) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      held_item <= in_item;
    end
  end

endmodule

// ===== rtl/trme_core.sv =====
// machine state and combinational instruction execution
// depends on trme_pkg

module trme_core
  import trme_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    advance,
  input  instr_t  item,
  output result_t result
);

  logic [NUM_REGS-1:0][DATA_W-1:0] regs;
  logic [NUM_REGS-1:0][DATA_W-1:0] regs_next;
  logic [IP_W-1:0]                 ip;
  logic [IP_W-1:0]                 ip_next;

  logic [DATA_W-1:0] opa;
  logic [DATA_W-1:0] opb;
  logic [DATA_W-1:0] imm_ext;
  logic [DATA_W-1:0] wval;
  logic              wen;
  logic              jumped;
  logic              halted;
  logic [IP_W-1:0]   ip_base;

  // operand read: general register, pointer, or zero
  function automatic logic [DATA_W-1:0] read_reg(
    input logic [IDX_W-1:0]                 idx,
    input logic [NUM_REGS-1:0][DATA_W-1:0]  r,
    input logic [IP_W-1:0]                  p
  );
    logic [DATA_W-1:0] v;
    v = '0;
    if (idx < IDX_W'(NUM_REGS)) begin
      v = r[idx[IDX_W-1:0]];
    end else if (idx == IP_INDEX) begin
      v = DATA_W'(p);
    end
    return v;
  endfunction

  assign opa     = read_reg(item.source_index, regs, ip);
  assign opb     = read_reg(item.dest_index, regs, ip);
  assign imm_ext = DATA_W'(item.immediate);

  // decode and compute the write value
  always_comb begin
    wen    = 1'b0;
    wval   = '0;
    jumped = 1'b0;
    halted = 1'b0;
    if (item.mode == MODE_PRESET) begin
      wen  = 1'b1;
      wval = item.preset_value;
    end else begin
      case (op_t'(item.opcode))
        OP_HALT:    halted = 1'b1;
        OP_LOADIMM: begin wen = 1'b1; wval = imm_ext; end
        OP_ADD:     begin wen = 1'b1; wval = opa + opb; end
        OP_ADDIMM:  begin wen = 1'b1; wval = opa + imm_ext; end
        OP_AND:     begin wen = 1'b1; wval = opa & opb; end
        OP_OR:      begin wen = 1'b1; wval = opa | opb; end
        OP_XOR:     begin wen = 1'b1; wval = opa ^ opb; end
        OP_JUMP:    jumped = 1'b1;
        OP_BEQ:     jumped = (opa == opb);
        OP_MOVE:    begin wen = 1'b1; wval = opa; end
        default:    ;
      endcase
    end
  end

  // next register file and pointer
  always_comb begin
    regs_next = regs;
    ip_base   = ip;
    if (wen && item.dest_index < IDX_W'(NUM_REGS)) begin
      regs_next[item.dest_index] = wval;
    end
    if (wen && item.dest_index == IP_INDEX) begin
      ip_base = wval[IP_W-1:0];
    end
    if (item.mode == MODE_PRESET || halted) begin
      ip_next = ip_base;
    end else if (jumped) begin
      ip_next = imm_ext[IP_W-1:0];
    end else begin
      ip_next = ip_base + IP_W'(1);
    end
  end

  // state update once per executed item
  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
      ip   <= '0;
    end else if (advance) begin
      regs <= regs_next;
      ip   <= ip_next;
    end
  end

  assign result.next_ip = ip_next;
  assign result.halted  = halted;
  assign result.regs    = regs_next;

endmodule

// ===== rtl/trme_out_reg.sv =====
// result register of the execute block
// depends on trme_pkg

module trme_out_reg
  import trme_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    held_valid,
  input  result_t result,
  output logic    advance,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_result
);

  // move an item on when the result slot is empty or being taken
  assign advance = held_valid & (~out_valid | ~out_stall);

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= result;
    end
  end

endmodule

// ===== rtl/toy_register_machine_execute.sv =====
// top level of the toy register machine execute block
// depends on trme_pkg, trme_in_reg, trme_core, trme_out_reg
//
//   channel  handshake             payload
//   in       in_valid / in_stall   mode opcode source_index dest_index immediate preset_value
//   out      out_valid / out_stall next_ip halted r0_value .. r4_value
//
// one item per cycle sustained while the output is not stalled
// the state update and result for an item are computed combinationally between the
// input register and the result register
// synchronous reset clears all registers and the pointer to zero
// a stall on the output holds the result and then stalls the input

module toy_register_machine_execute
  import trme_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     mode,
  input  logic [OP_W-1:0]          opcode,
  input  logic [IDX_W-1:0]         source_index,
  input  logic [IDX_W-1:0]         dest_index,
  input  logic signed [IMM_W-1:0]  immediate,
  input  logic signed [DATA_W-1:0] preset_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [IP_W-1:0]          next_ip,
  output logic                     halted,
  output logic signed [DATA_W-1:0] r0_value,
  output logic signed [DATA_W-1:0] r1_value,
  output logic signed [DATA_W-1:0] r2_value,
  output logic signed [DATA_W-1:0] r3_value,
  output logic signed [DATA_W-1:0] r4_value
);

  instr_t  in_item;
  instr_t  held_item;
  logic    held_valid;
  logic    advance;
  result_t result;
  result_t out_result;

  // pack input fields
  always_comb begin
    in_item.mode         = mode;
    in_item.opcode       = opcode;
    in_item.source_index = source_index;
    in_item.dest_index   = dest_index;
    in_item.immediate    = immediate;
    in_item.preset_value = preset_value;
  end

  trme_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  trme_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (held_item),
    .result  (result)
  );

  trme_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .held_valid (held_valid),
    .result     (result),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (out_result)
  );

  // unpack result fields
  assign next_ip  = out_result.next_ip;
  assign halted   = out_result.halted;
  assign r0_value = out_result.regs[0];
  assign r1_value = out_result.regs[1];
  assign r2_value = out_result.regs[2];
  assign r3_value = out_result.regs[3];
  assign r4_value = out_result.regs[4];

endmodule

// ===== bench/tb_top.sv =====
// testbench for toy_register_machine_execute: a directed table, then random instructions,
// each result checked field by field against an in-bench model of the register machine or a hand-written row
// depends on trme_pkg and the rtl of the block

module tb_top;
  import trme_pkg::*;

  localparam int RANDOM_ITEMS = 430;
  localparam int CALM_ITEMS   = 50;
  localparam int HOLD_CYCLES  = 48;
  localparam int WATCH_LIMIT  = 500;

  // register indexes
  localparam logic [IDX_W-1:0] IDX_R0     = 3'd0;
  localparam logic [IDX_W-1:0] IDX_R1     = 3'd1;
  localparam logic [IDX_W-1:0] IDX_R2     = 3'd2;
  localparam logic [IDX_W-1:0] IDX_R3     = 3'd3;
  localparam logic [IDX_W-1:0] IDX_R4     = 3'd4;
  localparam logic [IDX_W-1:0] IDX_SPARE6 = 3'd6;
  localparam logic [IDX_W-1:0] IDX_SPARE7 = 3'd7;

  // opcodes with no instruction behind them
  localparam logic [OP_W-1:0] OP_INVALID_LO = 4'd10;
  localparam logic [OP_W-1:0] OP_INVALID_HI = 4'd15;

  typedef struct {
    instr_t  item;
    logic    typed;
    result_t want;
  } stim_row_t;

  logic                     clk          = 1'b0;
  logic                     rst          = 1'b1;
  logic                     in_valid     = 1'b0;
  logic                     in_stall;
  logic                     mode         = MODE_EXEC;
  logic [OP_W-1:0]          opcode       = '0;
  logic [IDX_W-1:0]         source_index = '0;
  logic [IDX_W-1:0]         dest_index   = '0;
  logic signed [IMM_W-1:0]  immediate    = '0;
  logic signed [DATA_W-1:0] preset_value = '0;
  logic                     out_valid;
  logic                     out_stall    = 1'b0;
  logic [IP_W-1:0]          next_ip;
  logic                     halted;
  logic signed [DATA_W-1:0] r0_value;
  logic signed [DATA_W-1:0] r1_value;
  logic signed [DATA_W-1:0] r2_value;
  logic signed [DATA_W-1:0] r3_value;
  logic signed [DATA_W-1:0] r4_value;

  // typed expectation that travels with the item on the bus
  logic    row_typed = 1'b0;
  result_t row_want  = '0;

  // machine state as the bench sees it
  logic [DATA_W-1:0] machine_regs [NUM_REGS];
  logic [IP_W-1:0]   machine_ip;

  stim_row_t directed_rows [$];
  result_t   expected_results [$];
  result_t   predicted;
  result_t   oldest;
  int        mismatches     = 0;
  int        accepted_items = 0;
  int        quiet_cycles   = 0;
  bit        calm           = 1'b0;
  bit        held           = 1'b0;

  toy_register_machine_execute dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .opcode       (opcode),
    .source_index (source_index),
    .dest_index   (dest_index),
    .immediate    (immediate),
    .preset_value (preset_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .next_ip      (next_ip),
    .halted       (halted),
    .r0_value     (r0_value),
    .r1_value     (r1_value),
    .r2_value     (r2_value),
    .r3_value     (r3_value),
    .r4_value     (r4_value)
  );

  always #6 clk = ~clk;

  // register file access, pointer readable and writable as index five
  function automatic logic [DATA_W-1:0] read_index(input logic [IDX_W-1:0] idx);
    if (idx < NUM_REGS) return machine_regs[idx];
    if (idx == IP_INDEX) return DATA_W'(machine_ip);
    return '0;
  endfunction

  function automatic void write_index(input logic [IDX_W-1:0] idx, input logic [DATA_W-1:0] v);
    if (idx < NUM_REGS) machine_regs[idx] = v;
    else if (idx == IP_INDEX) machine_ip = v[IP_W-1:0];
  endfunction

  // run one item on the bench copy of the machine, return the result it gives
  function automatic result_t execute_item(input logic m, input logic [OP_W-1:0] op,
                                           input logic [IDX_W-1:0] src,
                                           input logic [IDX_W-1:0] dst,
                                           input logic [IMM_W-1:0] imm,
                                           input logic [DATA_W-1:0] pv);
    result_t           r;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic [DATA_W-1:0] imm_x;
    logic              jumped;
    r = '0;
    jumped = 1'b0;
    imm_x = {{(DATA_W-IMM_W){imm[IMM_W-1]}}, imm};
    a = read_index(src);
    b = read_index(dst);
    if (m == MODE_PRESET) begin
      write_index(dst, pv);
    end else if (op == OP_HALT) begin
      r.halted = 1'b1;
    end else begin
      case (op)
        OP_LOADIMM: write_index(dst, imm_x);
        OP_ADD:     write_index(dst, a + b);
        OP_ADDIMM:  write_index(dst, a + imm_x);
        OP_AND:     write_index(dst, a & b);
        OP_OR:      write_index(dst, a | b);
        OP_XOR:     write_index(dst, a ^ b);
        OP_MOVE:    write_index(dst, a);
        OP_JUMP: begin
          machine_ip = imm_x[IP_W-1:0];
          jumped = 1'b1;
        end
        OP_BEQ: begin
          if (a == b) begin
            machine_ip = imm_x[IP_W-1:0];
            jumped = 1'b1;
          end
        end
        default: ;
      endcase
      if (!jumped) machine_ip = machine_ip + 1'b1;
    end
    r.next_ip = machine_ip;
    for (int i = 0; i < NUM_REGS; i++) r.regs[i] = machine_regs[i];
    return r;
  endfunction

  function automatic void check_field(input string field, input logic [DATA_W-1:0] want,
                                      input logic [DATA_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch in %s: expected %h, got %h", field, want, got);
    end
  endfunction

  function automatic void add_row(input logic m, input logic [OP_W-1:0] op,
                                  input logic [IDX_W-1:0] src, input logic [IDX_W-1:0] dst,
                                  input logic [IMM_W-1:0] imm, input logic [DATA_W-1:0] pv);
    stim_row_t row;
    row.item = '{mode: m, opcode: op, source_index: src, dest_index: dst,
                 immediate: imm, preset_value: pv};
    row.typed = 1'b0;
    row.want = '0;
    directed_rows.push_back(row);
  endfunction

  // row whose result is written out by hand
  function automatic void add_typed(input logic m, input logic [OP_W-1:0] op,
                                    input logic [IDX_W-1:0] src, input logic [IDX_W-1:0] dst,
                                    input logic [IMM_W-1:0] imm, input logic [DATA_W-1:0] pv,
                                    input logic [IP_W-1:0] ip, input logic h,
                                    input logic [DATA_W-1:0] v0, input logic [DATA_W-1:0] v1,
                                    input logic [DATA_W-1:0] v2, input logic [DATA_W-1:0] v3,
                                    input logic [DATA_W-1:0] v4);
    add_row(m, op, src, dst, imm, pv);
    directed_rows[$].typed = 1'b1;
    directed_rows[$].want.next_ip = ip;
    directed_rows[$].want.halted = h;
    directed_rows[$].want.regs[0] = v0;
    directed_rows[$].want.regs[1] = v1;
    directed_rows[$].want.regs[2] = v2;
    directed_rows[$].want.regs[3] = v3;
    directed_rows[$].want.regs[4] = v4;
  endfunction

  // put one item on the input and hold it until it is taken
  task automatic offer_item(input stim_row_t row);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    mode         <= row.item.mode;
    opcode       <= row.item.opcode;
    source_index <= row.item.source_index;
    dest_index   <= row.item.dest_index;
    immediate    <= row.item.immediate;
    preset_value <= row.item.preset_value;
    row_typed    <= row.typed;
    row_want     <= row.want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // acceptance, prediction, result checking and watchdog
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) machine_regs[i] = '0;
      machine_ip = '0;
      expected_results.delete();
      quiet_cycles = 0;
    end else begin
      if (in_valid && !in_stall) begin
        predicted = execute_item(mode, opcode, source_index, dest_index, immediate,
                                 preset_value);
        if (row_typed) predicted = row_want;
        expected_results.push_back(predicted);
        accepted_items++;
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result with nothing expected, next_ip %h", next_ip);
        end else begin
          oldest = expected_results.pop_front();
          check_field("next_ip", DATA_W'(oldest.next_ip), DATA_W'(next_ip));
          check_field("halted", DATA_W'(oldest.halted), DATA_W'(halted));
          check_field("r0_value", oldest.regs[0], r0_value);
          check_field("r1_value", oldest.regs[1], r1_value);
          check_field("r2_value", oldest.regs[2], r2_value);
          check_field("r3_value", oldest.regs[3], r3_value);
          check_field("r4_value", oldest.regs[4], r4_value);
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles == WATCH_LIMIT) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
  end

  // result side: random stall bursts until the calm tail, with one long hold-off once 60 items are accepted
  initial begin
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (!held && accepted_items >= 60) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // stimulus: directed table, then random items, then drain
  initial begin
    stim_row_t row;
    int        pick;

    // halt with junk operands, then presets at the value extremes
    add_typed(MODE_EXEC, OP_HALT, IDX_SPARE7, IDX_SPARE7, 8'hFF, 32'hFFFF_FFFF,
              8'h00, 1'b1, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
    add_typed(MODE_PRESET, OP_HALT, IDX_R0, IDX_R0, 8'h00, 32'h7FFF_FFFF,
              8'h00, 1'b0, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0);
    add_typed(MODE_PRESET, OP_ADD, IDX_R4, IDX_R1, 8'h00, 32'h8000_0000,
              8'h00, 1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 32'h0);
    // every instruction that writes a register, a sum that wraps, immediates at both ends
    add_row(MODE_EXEC, OP_ADD, IDX_R1, IDX_R0, 8'h00, 32'hFFFF_FFFF);
    add_row(MODE_EXEC, OP_ADDIMM, IDX_R0, IDX_R2, 8'h01, 32'h0);
    add_row(MODE_EXEC, OP_LOADIMM, IDX_R1, IDX_R3, 8'h80, 32'h0);
    add_row(MODE_EXEC, OP_LOADIMM, IDX_R2, IDX_R4, 8'h7F, 32'h0);
    add_row(MODE_EXEC, OP_AND, IDX_R0, IDX_R3, 8'h00, 32'h0);
    add_row(MODE_EXEC, OP_OR, IDX_R4, IDX_R1, 8'h00, 32'h0);
    add_row(MODE_EXEC, OP_XOR, IDX_R0, IDX_R4, 8'h00, 32'h0);
    add_row(MODE_EXEC, OP_MOVE, IDX_R4, IDX_R2, 8'h00, 32'h0);
    // negative jump target, pointer wrap through invalid opcodes
    add_row(MODE_EXEC, OP_JUMP, IDX_SPARE7, IDX_SPARE6, 8'hFF, 32'h0);
    add_row(MODE_EXEC, OP_INVALID_LO, IDX_R0, IDX_R0, 8'h00, 32'h0);
    add_row(MODE_EXEC, OP_INVALID_HI, IDX_R1, IDX_R2, 8'h33, 32'h0);
    // branch taken and not taken
    add_row(MODE_EXEC, OP_BEQ, IDX_R3, IDX_R4, 8'h40, 32'h0);
    add_row(MODE_EXEC, OP_BEQ, IDX_R0, IDX_R1, 8'h10, 32'h0);
    // pointer as preset target, source and destination
    add_row(MODE_PRESET, OP_HALT, IDX_R0, IP_INDEX, 8'h00, 32'h0000_0123);
    add_row(MODE_EXEC, OP_MOVE, IP_INDEX, IDX_R0, 8'h00, 32'h0);
    add_row(MODE_EXEC, OP_ADDIMM, IP_INDEX, IP_INDEX, 8'h0A, 32'h0);
    // spare indexes read zero and swallow writes
    add_row(MODE_EXEC, OP_LOADIMM, IDX_R0, IDX_SPARE6, 8'h55, 32'h0);
    add_row(MODE_EXEC, OP_MOVE, IDX_SPARE7, IDX_R1, 8'h00, 32'h0);
    add_row(MODE_PRESET, OP_HALT, IDX_R0, IDX_SPARE7, 8'h00, 32'hA5A5_A5A5);
    add_row(MODE_EXEC, OP_BEQ, IDX_SPARE6, IDX_SPARE7, 8'h80, 32'h0);
    add_row(MODE_EXEC, OP_JUMP, IDX_R0, IDX_R0, 8'h7F, 32'h0);
    add_row(MODE_EXEC, OP_ADD, IP_INDEX, IP_INDEX, 8'h00, 32'h0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int k = 0; k < directed_rows.size(); k++) offer_item(directed_rows[k]);

    // random instructions, mostly valid ones on the general registers
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n >= RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      row.typed = 1'b0;
      row.want = '0;
      row.item.mode = ($urandom_range(0, 99) < 20) ? MODE_PRESET : MODE_EXEC;
      pick = $urandom_range(0, 99);
      if (pick < 6) row.item.opcode = OP_HALT;
      else if (pick < 90) row.item.opcode = OP_W'($urandom_range(OP_LOADIMM, OP_MOVE));
      else row.item.opcode = OP_W'($urandom_range(OP_INVALID_LO, OP_INVALID_HI));
      row.item.source_index = ($urandom_range(0, 99) < 80) ? IDX_W'($urandom_range(0, 4))
                                                           : IDX_W'($urandom_range(0, 7));
      row.item.dest_index = ($urandom_range(0, 99) < 80) ? IDX_W'($urandom_range(0, 4))
                                                         : IDX_W'($urandom_range(0, 7));
      // same register on both sides makes branches taken now and then
      if ($urandom_range(0, 9) == 0) row.item.dest_index = row.item.source_index;
      row.item.immediate = IMM_W'($urandom_range(0, 255));
      case ($urandom_range(0, 3))
        0: row.item.preset_value = DATA_W'($urandom_range(0, 15));
        1: begin
          pick = $urandom_range(0, 2);
          row.item.preset_value = (pick == 0) ? 32'h8000_0000 :
                                  (pick == 1) ? 32'h7FFF_FFFF : 32'hFFFF_FFFF;
        end
        default: row.item.preset_value = $urandom;
      endcase
      offer_item(row);
    end
    in_valid <= 1'b0;

    // let the last results drain
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/trme_pkg.sv
rtl/trme_in_reg.sv
rtl/trme_core.sv
rtl/trme_out_reg.sv
rtl/toy_register_machine_execute.sv
bench/tb_top.sv
